// ===== src/cmi_pkg.sv =====
// Package for the colormap interpolator: table sizes, register indexes and
// controller state type. Used by colormap_interpolator_core and its checker.
`default_nettype none
package cmi_pkg;
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = IDX_W + 1;

  typedef enum logic [2:0] {
    REG_ENTRY_COUNT = 3'd0,
    REG_GAIN        = 3'd1,
    REG_OFFSET      = 3'd2,
    REG_NAN_RED     = 3'd3,
    REG_NAN_GREEN   = 3'd4,
    REG_NAN_BLUE    = 3'd5
  } reg_index_t;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_MAP  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_READ,
    ST_CMP,
    ST_NUMER,
    ST_DIV,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== src/colormap_interpolator_core.sv =====
// Colormap interpolator top level: breakpoint memories, scaler, search and
// per-channel restoring divider. Depends on cmi_pkg.
//
//  channel | signals                                          | handshake
//  in      | kind entry_* sample sample_is_nan                | in_valid / in_stall
//  out     | red green blue                                   | out_valid / out_stall
//  cfg     | cfg_index cfg_data                               | cfg_valid / cfg_ready
//
// A load leaves the input free. A NaN sample goes straight to hand-over. Other
// samples are accepted and scaled, then compared with one breakpoint at a time
// via the registered read of the level memory (one read port), then, when
// interpolating, a numerator step and an 8-bit restoring division, then
// hand-over; below the first or at the last level there is no division. Reset
// is synchronous and clears control and configuration state only. Input stalls
// while an item is at work; a stalled output holds and a finished item waits.
`default_nettype none
module colormap_interpolator_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                kind,
  input  wire logic [3:0]          entry_index,
  input  wire logic signed [31:0]  entry_level,
  input  wire logic [7:0]          entry_red,
  input  wire logic [7:0]          entry_green,
  input  wire logic [7:0]          entry_blue,
  input  wire logic signed [31:0]  sample,
  input  wire logic                sample_is_nan,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               red,
  output logic [7:0]               green,
  output logic [7:0]               blue,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);
  localparam int IW = cmi_pkg::IDX_W;
  localparam int CW = cmi_pkg::CNT_W;

  logic signed [31:0] level_mem [cmi_pkg::MAX_ENTRIES];
  logic [23:0]        colour_mem [cmi_pkg::MAX_ENTRIES];
  logic signed [31:0] level_q;
  logic [23:0]        colour_q;

  logic [4:0]         entry_count;
  logic signed [31:0] gain;
  logic signed [31:0] offset;
  logic [7:0]         nan_red, nan_green, nan_blue;

  cmi_pkg::state_t    state, state_next;
  logic signed [31:0] sample_q;
  logic signed [63:0] prod;
  logic signed [31:0] scaled;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      n_used;
  logic signed [31:0] prev_level;
  logic [23:0]        prev_colour;
  logic [31:0]        num, den;
  logic [39:0]        rem [3];
  logic [7:0]         quo [3];
  logic [2:0]         step;
  logic [23:0]        result;

  logic               accept;
  logic               out_free;
  logic               is_last;
  logic               below;
  logic signed [63:0] shifted;
  logic signed [63:0] sum;
  logic [IW-1:0]      rd_addr;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign below    = scaled < level_q;
  assign is_last  = (idx + CW'(1)) == n_used;
  assign shifted  = prod >>> 16;
  assign sum      = shifted + 64'(offset);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (entry_count == 5'd0) begin
      n_used = CW'(1);
    end else if (32'(entry_count) > cmi_pkg::MAX_ENTRIES) begin
      n_used = CW'(cmi_pkg::MAX_ENTRIES);
    end else begin
      n_used = CW'(entry_count);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cmi_pkg::ST_IDLE: begin
        if (accept && kind == cmi_pkg::KIND_MAP) begin
          state_next = sample_is_nan ? cmi_pkg::ST_OUT : cmi_pkg::ST_MUL;
        end
      end
      cmi_pkg::ST_MUL:   state_next = cmi_pkg::ST_SCALE;
      cmi_pkg::ST_SCALE: state_next = cmi_pkg::ST_READ;
      cmi_pkg::ST_READ:  state_next = cmi_pkg::ST_CMP;
      cmi_pkg::ST_CMP: begin
        if (below) begin
          state_next = (idx == '0) ? cmi_pkg::ST_OUT : cmi_pkg::ST_NUMER;
        end else if (is_last) begin
          state_next = cmi_pkg::ST_OUT;
        end else begin
          state_next = cmi_pkg::ST_READ;
        end
      end
      cmi_pkg::ST_NUMER: state_next = cmi_pkg::ST_DIV;
      cmi_pkg::ST_DIV: begin
        if (step == 3'd7) begin
          state_next = cmi_pkg::ST_OUT;
        end
      end
      cmi_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = cmi_pkg::ST_IDLE;
        end
      end
      default: state_next = cmi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != cmi_pkg::ST_IDLE);
    rd_addr  = idx[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept && kind == cmi_pkg::KIND_LOAD &&
        32'(entry_index) < cmi_pkg::MAX_ENTRIES) begin
      level_mem[IW'(entry_index)]  <= entry_level;
      colour_mem[IW'(entry_index)] <= {entry_red, entry_green, entry_blue};
    end
    level_q  <= level_mem[rd_addr];
    colour_q <= colour_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= 5'd1;
      gain        <= 32'sd65536;
      offset      <= '0;
      nan_red     <= '0;
      nan_green   <= '0;
      nan_blue    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cmi_pkg::REG_ENTRY_COUNT: entry_count <= cfg_data[4:0];
        cmi_pkg::REG_GAIN:        gain        <= cfg_data;
        cmi_pkg::REG_OFFSET:      offset      <= cfg_data;
        cmi_pkg::REG_NAN_RED:     nan_red     <= cfg_data[7:0];
        cmi_pkg::REG_NAN_GREEN:   nan_green   <= cfg_data[7:0];
        cmi_pkg::REG_NAN_BLUE:    nan_blue    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cmi_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == cmi_pkg::ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      cmi_pkg::ST_IDLE: begin
        sample_q <= sample;
        idx      <= '0;
        result   <= {nan_red, nan_green, nan_blue};
      end
      cmi_pkg::ST_MUL: prod <= gain * sample_q;
      cmi_pkg::ST_SCALE: begin
        if (sum > 64'sd2147483647) begin
          scaled <= 32'sh7fffffff;
        end else if (sum < -64'sd2147483648) begin
          scaled <= 32'sh80000000;
        end else begin
          scaled <= sum[31:0];
        end
      end
      cmi_pkg::ST_CMP: begin
        idx    <= idx + CW'(1);
        num    <= 32'(33'(scaled) - 33'(prev_level));
        den    <= 32'(33'(level_q) - 33'(prev_level));
        step   <= '0;
        result <= colour_q;
        if (!below) begin
          prev_level  <= level_q;
          prev_colour <= colour_q;
        end
      end
      cmi_pkg::ST_NUMER: begin
        for (int k = 0; k < 3; k++) begin
          rem[k] <= 40'(prev_colour[16-8*k +: 8]) * 40'(den - num)
                  + 40'(result[16-8*k +: 8]) * 40'(num);
        end
      end
      cmi_pkg::ST_DIV: begin
        step <= step + 3'd1;
        for (int k = 0; k < 3; k++) begin
          if (rem[k] >= (40'(den) << (3'd7 - step))) begin
            rem[k] <= rem[k] - (40'(den) << (3'd7 - step));
            quo[k] <= {quo[k][6:0], 1'b1};
          end else begin
            quo[k] <= {quo[k][6:0], 1'b0};
          end
        end
        if (step == 3'd7) begin
          result <= {quo[0][6:0], rem[0] >= 40'(den),
                     quo[1][6:0], rem[1] >= 40'(den),
                     quo[2][6:0], rem[2] >= 40'(den)};
        end
      end
      default: ;
    endcase
    if (state == cmi_pkg::ST_OUT && out_free) begin
      red   <= result[23:16];
      green <= result[15:8];
      blue  <= result[7:0];
    end
  end
endmodule
`default_nettype wire

// ===== src/cmi_checker.sv =====
// Port-level checker for colormap_interpolator_core, bound to the top level.
// Depends on cmi_pkg for the item kind codes.
`default_nettype none
module cmi_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       kind,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] red,
  input wire logic [7:0] green,
  input wire logic [7:0] blue
);
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
    else $error("stalled result changed");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind == cmi_pkg::KIND_LOAD |=> !in_stall)
    else $error("load transfer blocked the input");

  a_map_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind == cmi_pkg::KIND_MAP |=> in_stall)
    else $error("sample transfer did not hold the input");
endmodule

bind colormap_interpolator_core cmi_checker u_cmi_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
  .out_valid(out_valid), .out_stall(out_stall), .red(red), .green(green), .blue(blue)
);
`default_nettype wire

// ===== test/tb.sv =====
// Testbench for colormap_interpolator_core: drives breakpoint loads, register
// writes and samples, predicts each mapped colour with an in-bench scaler and
// interpolator. Depends on cmi_pkg and colormap_interpolator_core.
`default_nettype none
module tb;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = cmi_pkg::KIND_LOAD;
  logic [3:0] entry_index = '0;
  logic signed [31:0] entry_level = '0;
  logic [7:0] entry_red = '0, entry_green = '0, entry_blue = '0;
  logic signed [31:0] sample = '0;
  logic sample_is_nan = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] red, green, blue;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  colormap_interpolator_core uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  logic signed [31:0] level_mem [cmi_pkg::MAX_ENTRIES];
  rgb_t colour_mem [cmi_pkg::MAX_ENTRIES];
  logic [4:0] count_reg = 5'd1;
  logic signed [31:0] gain_reg = 32'sd65536;
  logic signed [31:0] offset_reg = '0;
  rgb_t nan_colour = '0;
  rgb_t colour_q[$];
  int errors = 0;
  int hold_off = 0;
  int wait_left = 0;
  bit pressure = 0;

  function automatic logic signed [31:0] scaled(logic signed [31:0] s);
    logic signed [63:0] p;
    logic signed [64:0] sum;
    p = 64'(gain_reg) * 64'(s);
    sum = 65'(p >>> 16) + 65'(offset_reg);
    if (sum > 65'sd2147483647) return 32'h7fffffff;
    if (sum < -65'sd2147483648) return 32'h80000000;
    return sum[31:0];
  endfunction

  function automatic logic [7:0] blend(logic [7:0] c0, logic [7:0] c1,
                                       logic [32:0] num, logic [32:0] den);
    logic [47:0] t;
    t = 48'(c0) * 48'(den - num) + 48'(c1) * 48'(num);
    return 8'(t / 48'(den));
  endfunction

  function automatic rgb_t mapped_colour(logic signed [31:0] s, logic nan);
    int n;
    logic signed [31:0] d;
    logic [32:0] num, den;
    rgb_t c;
    if (nan) return nan_colour;
    n = count_reg == 0 ? 1
        : (count_reg > cmi_pkg::MAX_ENTRIES ? cmi_pkg::MAX_ENTRIES : count_reg);
    d = scaled(s);
    if (d < level_mem[0]) return colour_mem[0];
    for (int m = 1; m < n; m++) begin
      if (d < level_mem[m]) begin
        num = 33'(34'(d) - 34'(level_mem[m-1]));
        den = 33'(34'(level_mem[m]) - 34'(level_mem[m-1]));
        c.r = blend(colour_mem[m-1].r, colour_mem[m].r, num, den);
        c.g = blend(colour_mem[m-1].g, colour_mem[m].g, num, den);
        c.b = blend(colour_mem[m-1].b, colour_mem[m].b, num, den);
        return c;
      end
    end
    return colour_mem[n-1];
  endfunction

  task automatic send_item(logic k, logic [3:0] idx, logic signed [31:0] lvl, rgb_t c,
                           logic signed [31:0] s, logic nan);
    int gap;
    gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 14);
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    entry_index <= idx;
    entry_level <= lvl;
    {entry_red, entry_green, entry_blue} <= c;
    sample <= s;
    sample_is_nan <= nan;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (k == cmi_pkg::KIND_LOAD) begin
      level_mem[idx] = lvl;
      colour_mem[idx] = c;
    end else begin
      colour_q.push_back(mapped_colour(s, nan));
    end
  endtask

  task automatic load_entry(int idx, logic signed [31:0] lvl, rgb_t c);
    send_item(cmi_pkg::KIND_LOAD, idx[3:0], lvl, c, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic map_sample(logic signed [31:0] s, logic nan);
    send_item(cmi_pkg::KIND_MAP, 4'($urandom), $urandom, rgb_t'($urandom), s, nan);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (colour_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(cmi_pkg::reg_index_t idx, logic [31:0] data);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      cmi_pkg::REG_ENTRY_COUNT: count_reg = data[4:0];
      cmi_pkg::REG_GAIN:        gain_reg = data;
      cmi_pkg::REG_OFFSET:      offset_reg = data;
      cmi_pkg::REG_NAN_RED:     nan_colour.r = data[7:0];
      cmi_pkg::REG_NAN_GREEN:   nan_colour.g = data[7:0];
      cmi_pkg::REG_NAN_BLUE:    nan_colour.b = data[7:0];
      default: ;
    endcase
  endtask

  // sorted random levels across the whole table
  task automatic load_ramp(int spread);
    logic signed [31:0] lvl;
    lvl = -$signed(32'($urandom_range(0, spread)));
    for (int i = 0; i < cmi_pkg::MAX_ENTRIES; i++) begin
      load_entry(i, lvl, rgb_t'($urandom));
      lvl = lvl + 1 + $urandom_range(0, spread / 8);
    end
  endtask

  task automatic test_directed;
    load_entry(0, 32'sh80000000, '{8'h00, 8'hff, 8'h00});
    load_entry(1, 32'sd0, '{8'hff, 8'h00, 8'hff});
    load_entry(2, 32'sh7fffffff, '{8'h12, 8'h34, 8'h56});
    for (int i = 3; i < cmi_pkg::MAX_ENTRIES; i++)
      load_entry(i, 32'sh7fffffff, '{8'hff, 8'hff, 8'hff});
    write_reg(cmi_pkg::REG_ENTRY_COUNT, 32'd3);
    write_reg(cmi_pkg::REG_NAN_RED, 32'hff);
    write_reg(cmi_pkg::REG_NAN_GREEN, 32'h01);
    write_reg(cmi_pkg::REG_NAN_BLUE, 32'h80);
    map_sample(32'sh80000000, 1'b0);
    map_sample(32'sh7fffffff, 1'b0);
    map_sample(32'sd0, 1'b0);
    map_sample(-32'sd1, 1'b0);
    map_sample(32'sh12345678, 1'b1);
    map_sample(32'sh7ffffffe, 1'b0);
    drain();
    write_reg(cmi_pkg::REG_GAIN, 32'h7fffffff);
    write_reg(cmi_pkg::REG_OFFSET, 32'h80000000);
    map_sample(32'sh7fffffff, 1'b0);
    map_sample(32'sh80000000, 1'b0);
    map_sample(32'sd3, 1'b0);
    drain();
    write_reg(cmi_pkg::REG_GAIN, 32'h80000000);
    write_reg(cmi_pkg::REG_OFFSET, 32'h7fffffff);
    map_sample(32'sh80000000, 1'b0);
    map_sample(-32'sd1, 1'b0);
    map_sample(32'sh7fffffff, 1'b0);
    drain();
    write_reg(cmi_pkg::REG_ENTRY_COUNT, 32'd0);
    map_sample(32'sd5, 1'b0);
    drain();
    write_reg(cmi_pkg::REG_ENTRY_COUNT, 32'd31);
    map_sample(32'sd5, 1'b0);
    load_entry(15, 32'sd100, '{8'h01, 8'h02, 8'h03});
    map_sample(32'sd200, 1'b0);
    drain();
  endtask

  task automatic test_random(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      write_reg(cmi_pkg::REG_ENTRY_COUNT, $urandom_range(0, 31));
      write_reg(cmi_pkg::REG_GAIN, $urandom_range(0, 3) == 0 ? $urandom
                : 32'($signed(32'($urandom_range(0, 262144))) - 131072));
      write_reg(cmi_pkg::REG_OFFSET, $urandom_range(0, 3) == 0 ? $urandom
                : 32'($signed(32'($urandom_range(0, 2000000))) - 1000000));
      write_reg(cmi_pkg::REG_NAN_RED, $urandom);
      write_reg(cmi_pkg::REG_NAN_GREEN, $urandom);
      write_reg(cmi_pkg::REG_NAN_BLUE, $urandom);
      load_ramp($urandom_range(0, 1) ? 1000 : 2000000);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 9) == 0)
          load_entry($urandom_range(0, 15), $urandom, rgb_t'($urandom));
        else if ($urandom_range(0, 5) == 0)
          map_sample($urandom, 1'($urandom_range(0, 1)));
        else
          map_sample(32'($signed(32'($urandom_range(0, 2400000))) - 1200000),
                     $urandom_range(0, 15) == 0);
      end
      drain();
    end
  endtask

  task automatic test_backpressure;
    pressure <= 1'b1;
    @(posedge clk);
    pressure <= 1'b0;
    for (int i = 0; i < 20; i++) map_sample($urandom, 1'b0);
    drain();
  endtask

  always @(posedge clk) begin
    int w;
    if (rst) begin
      out_stall <= 1'b0;
      hold_off <= 0;
      wait_left <= 0;
    end else if (pressure) begin
      hold_off <= 300;
      out_stall <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      w = $urandom_range(0, 14);
      wait_left <= w;
      out_stall <= w != 0;
    end else if (wait_left > 1) begin
      wait_left <= wait_left - 1;
      out_stall <= 1'b1;
    end else begin
      wait_left <= 0;
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    rgb_t want;
    if (!rst && out_valid && !out_stall) begin
      if (colour_q.size() == 0) begin
        $error("transfer with no colour expected");
        errors++;
      end else begin
        want = colour_q.pop_front();
        if (red !== want.r) begin
          $error("red expected %0h actual %0h", want.r, red);
          errors++;
        end
        if (green !== want.g) begin
          $error("green expected %0h actual %0h", want.g, green);
          errors++;
        end
        if (blue !== want.b) begin
          $error("blue expected %0h actual %0h", want.b, blue);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(16, 82);
    drain();
    if (errors == 0 && colour_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
src/cmi_pkg.sv
src/colormap_interpolator_core.sv
src/cmi_checker.sv
test/tb.sv
